// File: design/tli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg: shared types for the table linear interpolation block
// controller states, command and status bundles, divider constants
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DCNT_W    = 5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAST,
    ST_FIRST,
    ST_RANGE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_RESULT
  } tli_state_t;

  // controller to datapath
  typedef struct packed {
    logic wr;         // store one table entry
    logic q_load;     // capture query x
    logic rd_last;    // read entry n-1
    logic rd_first;   // read entry 0, capture last x
    logic range_chk;  // x0 on read port, range check
    logic scan;       // one interval compare
    logic mul;        // form the product
    logic div;        // one divide step
    logic fix;        // apply quotient to base y
    logic out_load;   // move result into output register
  } tli_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic oor;
    logic found;
    logic scan_end;
    logic div_last;
    logic out_free;
  } tli_stat_t;

endpackage

// File: design/tli_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_ram: generic single-write single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/tli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_ctrl: query sequencer
// walks range check, interval scan, multiply, serial divide and delivery
// ----------------------------------------------------------------------------
module tli_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_mode,
  output logic               in_ready,
  input  tli_pkg::tli_stat_t stat,
  output tli_pkg::tli_cmd_t  cmd
);

  import tli_pkg::*;

  tli_state_t state_r;
  tli_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_mode == MODE_QUERY)) state_nxt = ST_LAST;
      end
      ST_LAST:  state_nxt = ST_FIRST;
      ST_FIRST: state_nxt = ST_RANGE;
      ST_RANGE: begin
        state_nxt = stat.oor ? ST_RESULT : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.found) state_nxt = ST_MUL;
        else if (stat.scan_end) state_nxt = ST_RESULT;
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (stat.div_last) state_nxt = ST_FIX;
      end
      ST_FIX: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready   = rst_n;
        cmd.wr     = in_ready && in_valid && (in_mode == MODE_WRITE);
        cmd.q_load = in_ready && in_valid && (in_mode == MODE_QUERY);
      end
      ST_LAST:   cmd.rd_last   = 1'b1;
      ST_FIRST:  cmd.rd_first  = 1'b1;
      ST_RANGE:  cmd.range_chk = 1'b1;
      ST_SCAN:   cmd.scan      = 1'b1;
      ST_MUL:    cmd.mul       = 1'b1;
      ST_DIV:    cmd.div       = 1'b1;
      ST_FIX:    cmd.fix       = 1'b1;
      ST_RESULT: cmd.out_load  = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: design/tli_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_dp: table storage and interpolation datapath
// x/y memories, interval compare, 32x32 multiply, restoring divider
// ----------------------------------------------------------------------------
module tli_dp #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tli_pkg::tli_cmd_t   cmd,
  output tli_pkg::tli_stat_t  stat,
  input  logic [6:0]          entry_count,
  input  logic [5:0]          in_entry_index,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  input  logic signed [31:0]  in_query_x,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_result_y,
  output logic                out_out_of_range
);

  import tli_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW_D = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW   = (CW_D > 7) ? CW_D : 7;

  // entries in use, clamped to 2 .. TABLE_DEPTH
  logic [CW-1:0] cnt_ext;
  logic [CW-1:0] n_used;
  logic [AW-1:0] last_idx;

  assign cnt_ext  = CW'(entry_count);
  assign n_used   = (cnt_ext < CW'(2)) ? CW'(2) :
                    (cnt_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_ext;
  assign last_idx = AW'(n_used - CW'(1));

  // memories
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [DATA_W-1:0]     rd_x_raw;
  logic [DATA_W-1:0]     rd_y_raw;
  logic signed [31:0]    rd_x;
  logic signed [31:0]    rd_y;

  logic [AW-1:0]         i_r;

  assign wr_en   = cmd.wr && (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(in_entry_index);
  assign rd_addr = cmd.rd_last   ? last_idx :
                   cmd.rd_first  ? '0 :
                   cmd.range_chk ? AW'(1) : AW'(i_r + AW'(1));
  assign rd_x    = $signed(rd_x_raw);
  assign rd_y    = $signed(rd_y_raw);

  tli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_x_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_point_x),
    .raddr (rd_addr),
    .rdata (rd_x_raw)
  );

  tli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_y_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_point_y),
    .raddr (rd_addr),
    .rdata (rd_y_raw)
  );

  // working registers
  logic signed [31:0] q_r,      q_nxt;
  logic signed [31:0] last_x_r, last_x_nxt;
  logic signed [31:0] xl_r,     xl_nxt;
  logic signed [31:0] yl_r,     yl_nxt;
  logic [AW-1:0]      i_nxt;
  logic [31:0]        den_r,    den_nxt;
  logic [31:0]        dx_r,     dx_nxt;
  logic [31:0]        mag_r,    mag_nxt;
  logic               neg_r,    neg_nxt;
  logic [31:0]        rem_r,    rem_nxt;
  logic [31:0]        low_r,    low_nxt;
  logic [DCNT_W-1:0]  dcnt_r,   dcnt_nxt;
  logic [31:0]        res_r,    res_nxt;
  logic               oor_r,    oor_nxt;

  logic               found;
  logic               oor;
  logic signed [32:0] dy;
  logic [32:0]        dy_abs;
  logic [63:0]        prod;
  logic [32:0]        trial;
  logic               ge;

  assign found  = (q_r < rd_x);
  assign oor    = (q_r < rd_x) || (q_r > last_x_r);
  assign dy     = 33'(rd_y) - 33'(yl_r);
  assign dy_abs = dy[32] ? 33'(-dy) : 33'(dy);
  assign prod   = 64'(mag_r) * 64'(dx_r);
  assign trial  = {rem_r, low_r[31]};
  assign ge     = (trial >= {1'b0, den_r});

  always_comb begin
    q_nxt      = q_r;
    last_x_nxt = last_x_r;
    xl_nxt     = xl_r;
    yl_nxt     = yl_r;
    i_nxt      = i_r;
    den_nxt    = den_r;
    dx_nxt     = dx_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    rem_nxt    = rem_r;
    low_nxt    = low_r;
    dcnt_nxt   = dcnt_r;
    res_nxt    = res_r;
    oor_nxt    = oor_r;

    if (cmd.q_load) q_nxt = in_query_x;
    if (cmd.rd_first) last_x_nxt = rd_x;

    if (cmd.range_chk) begin
      xl_nxt  = rd_x;
      yl_nxt  = rd_y;
      i_nxt   = AW'(1);
      res_nxt = '0;
      oor_nxt = oor;
    end

    if (cmd.scan) begin
      if (found) begin
        den_nxt = 32'(rd_x - xl_r);
        dx_nxt  = 32'(q_r - xl_r);
        neg_nxt = dy[32];
        mag_nxt = dy_abs[31:0];
      end else begin
        // no interval closed: ends on the last point's y
        xl_nxt  = rd_x;
        yl_nxt  = rd_y;
        i_nxt   = AW'(i_r + AW'(1));
        res_nxt = rd_y;
        oor_nxt = 1'b0;
      end
    end

    if (cmd.mul) begin
      rem_nxt  = prod[63:32];
      low_nxt  = prod[31:0];
      dcnt_nxt = '0;
    end

    // restoring step, quotient bits shift into low_r
    if (cmd.div) begin
      rem_nxt  = ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      low_nxt  = {low_r[30:0], ge};
      dcnt_nxt = DCNT_W'(dcnt_r + DCNT_W'(1));
    end

    if (cmd.fix) begin
      res_nxt = neg_r ? 32'(yl_r - low_r) : 32'(yl_r + low_r);
      oor_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    q_r      <= q_nxt;
    last_x_r <= last_x_nxt;
    xl_r     <= xl_nxt;
    yl_r     <= yl_nxt;
    i_r      <= i_nxt;
    den_r    <= den_nxt;
    dx_r     <= dx_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    rem_r    <= rem_nxt;
    low_r    <= low_nxt;
    dcnt_r   <= dcnt_nxt;
    res_r    <= res_nxt;
    oor_r    <= oor_nxt;
  end

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_y_r,     out_y_nxt;
  logic        out_oor_r,   out_oor_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_y_nxt     = out_y_r;
    out_oor_nxt   = out_oor_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_y_nxt     = res_r;
      out_oor_nxt   = oor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_y_r   <= out_y_nxt;
    out_oor_r <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_y     = $signed(out_y_r);
  assign out_out_of_range = out_oor_r;

  assign stat.oor      = oor;
  assign stat.found    = found;
  assign stat.scan_end = (i_r == last_idx);
  assign stat.div_last = (dcnt_r == DCNT_W'(DIV_STEPS - 1));
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

// File: design/table_linear_interpolation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_linear_interpolation_top: piecewise linear lookup table, signed Q16.16
// write items store (x, y) entries, query items return interpolated y
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  mode, entry_index, point_x,
//                                            point_y, query_x
//   out      output     out_valid/out_ready  result_y, out_of_range
//   cfg      input      cfg_valid/cfg_ready  entry_count
//
// a write transfer is stored in the cycle it is taken; the next item can
// follow right away
// a query reads the last and first entries, checks the range, then scans
// one entry per cycle over the single memory read port; a closed interval
// is multiplied, passed through the 32-step serial divider and applied to
// the base y, else the last entry's y is used; out of range goes straight
// to the result. the next item is taken from the cycle the result appears
// synchronous active-low reset clears the sequencer, output valid and
// entry_count (to 2); table contents are not cleared
// a stalled output holds its result while the next item is already taken
// cfg_ready is high only while the sequencer is idle
//
module table_linear_interpolation_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // item channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_query_x,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_y,
  output logic               out_out_of_range,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_entry_count
);

  import tli_pkg::*;

  tli_cmd_t  cmd;
  tli_stat_t stat;

  // entry count register, written only while the block is idle
  logic [6:0] entry_count_r;
  logic [6:0] entry_count_nxt;

  assign cfg_ready       = in_ready;
  assign entry_count_nxt = (cfg_valid && cfg_ready) ? cfg_entry_count : entry_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= 7'd2;
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  // sequencer
  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, arithmetic and output register
  tli_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .entry_count      (entry_count_r),
    .in_entry_index   (in_entry_index),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_query_x       (in_query_x),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_y     (out_result_y),
    .out_out_of_range (out_out_of_range)
  );

  // a result never overwrites one still waiting to be taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an undelivered result");

  // no new item is taken while arithmetic is in flight
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.mul || cmd.div || cmd.fix || cmd.scan))
    else $error("input ready during query work");

  // an accepted query starts the sequence and drops ready
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_load |=> (!in_ready && cmd.rd_last))
    else $error("query accepted without starting the lookup");

  // the divider is entered only from the multiply step
  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div && !$past(cmd.div)) |-> $past(cmd.mul))
    else $error("divide started without a product");

endmodule
